// ----- rtl/psb_pkg.sv -----
// Package for the palette shade/blend nearest-colour block.
// Holds widths, constants and shared types; used by the distance unit and the top level.
`timescale 1ns / 1ps

package psb_pkg;

  // Palette storage
  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned PAL_AW      = 8;
  localparam int unsigned COMP_W      = 8;
  localparam int unsigned RGB_W       = 3 * COMP_W;

  // Colormap geometry
  localparam int unsigned ROW_W       = 9;
  localparam logic [8:0]  SHADE_ROWS  = 9'd64;
  localparam logic [8:0]  LAST_ROW    = 9'd319;
  localparam logic [5:0]  SHADE_MAX   = 6'd63;
  localparam int unsigned SHADE_SHIFT = 5;
  localparam logic [7:0]  LAST_INDEX  = 8'd255;

  // Target and distance widths
  localparam int unsigned TGT_W       = 9;
  localparam int unsigned DIST_W      = 11;
  localparam logic [10:0] DIST_LIMIT  = 11'd768;

  // Divide by three: x * 683 >> 11 is exact for x below 2048
  localparam logic [9:0]  RECIP3       = 10'd683;
  localparam int unsigned RECIP3_SHIFT = 11;

  // Actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [COMP_W-1:0] r;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [TGT_W-1:0] r;
    logic [TGT_W-1:0] g;
    logic [TGT_W-1:0] b;
  } target_t;

  typedef struct packed {
    logic clear;
    logic step;
  } dist_ctrl_t;

endpackage

// ----- rtl/psb_in_if.sv -----
// Input channel of the palette shade/blend block: valid/ready plus item fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface psb_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] entry_index;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [8:0] row;
  logic [7:0] column;

  modport source (
    output valid, action, entry_index, red_in, green_in, blue_in, row, column,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, red_in, green_in, blue_in, row, column,
    output ready
  );
endinterface

// ----- rtl/psb_out_if.sv -----
// Output channel of the palette shade/blend block: valid/ready plus result index.
// Depends on nothing.
`timescale 1ns / 1ps

interface psb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;

  modport source (
    output valid, color_index,
    input  ready
  );
  modport sink (
    input  valid, color_index,
    output ready
  );
endinterface

// ----- rtl/psb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module psb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/psb_dist_unit.sv -----
// Shared distance unit: sum of absolute RGB differences and running minimum.
// Depends on psb_pkg.
`timescale 1ns / 1ps

module psb_dist_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  psb_pkg::dist_ctrl_t         ctrl_i,
  input  psb_pkg::target_t            target_i,
  input  psb_pkg::rgb_t               entry_i,
  input  logic [psb_pkg::PAL_AW-1:0]  index_i,
  output logic [psb_pkg::PAL_AW-1:0]  best_idx_o
);

  logic [psb_pkg::TGT_W-1:0]  diff_r, diff_g, diff_b;
  logic [psb_pkg::DIST_W-1:0] entry_dist;
  logic [psb_pkg::DIST_W-1:0] best_dist_q, best_dist_d;
  logic [psb_pkg::PAL_AW-1:0] best_idx_q, best_idx_d;

  function automatic logic [psb_pkg::TGT_W-1:0] abs_diff(
    input logic [psb_pkg::COMP_W-1:0] a,
    input logic [psb_pkg::TGT_W-1:0]  t
  );
    logic [psb_pkg::TGT_W-1:0] ae;
    ae = {1'b0, a};
    return (ae > t) ? (ae - t) : (t - ae);
  endfunction

  // Distance of the current entry from the target
  always_comb begin
    diff_r     = abs_diff(entry_i.r, target_i.r);
    diff_g     = abs_diff(entry_i.g, target_i.g);
    diff_b     = abs_diff(entry_i.b, target_i.b);
    entry_dist = {2'b00, diff_r} + {2'b00, diff_g} + {2'b00, diff_b};
  end

  // Keep the first strict minimum below the limit
  always_comb begin
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    priority if (ctrl_i.clear) begin
      best_dist_d = psb_pkg::DIST_LIMIT;
      best_idx_d  = '0;
    end else if (ctrl_i.step && (entry_dist < best_dist_q)) begin
      best_dist_d = entry_dist;
      best_idx_d  = index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= psb_pkg::DIST_LIMIT;
      best_idx_q  <= '0;
    end else begin
      best_dist_q <= best_dist_d;
      best_idx_q  <= best_idx_d;
    end
  end

  assign best_idx_o = best_idx_q;

  // The running minimum never rises above the acceptance limit
  a_best_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_dist_q <= psb_pkg::DIST_LIMIT)
    else $error("best distance above limit");

endmodule

// ----- rtl/palette_shade_blend_nearest_color.sv -----
// Palette shade/blend nearest-colour top level: sequencer, target arithmetic and palette RAM.
// Depends on psb_pkg, psb_in_if, psb_out_if, psb_ram and psb_dist_unit.
`timescale 1ns / 1ps

// A palette write (action 0) is taken while idle and leaves the block idle and ready for the
// next item. A colormap query (action 1) reads the base colour and, in blending rows, the
// partner colour from the single read port of the palette RAM, forms the target colour,
// then walks entries 0 to 254 through one shared distance unit, one entry per cycle.
// A full query steps through capturing the base colour, capturing the partner colour
// when blending, forming the target, the scan over the RAM read port and loading the
// output register. Queries that hit column 255 or partner 255 skip the reads and the
// scan, go straight to the result stage and return index 255, and rows above 319
// are dropped without a result. The block accepts the next item while a result still
// waits in the output register; a query that finishes before that result is taken holds
// in its last stage until the output register frees. Palette entries must be written
// before a query reads them.
module palette_shade_blend_nearest_color (
  input  logic      clk_i,
  input  logic      rst_ni,
  psb_in_if.sink    in_ch_i,
  psb_out_if.source out_ch_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_RD_BASE = 6'b000010,
    ST_RD_PART = 6'b000100,
    ST_TARGET  = 6'b001000,
    ST_SCAN    = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_e;

  state_e                      state_q, state_d;
  logic [psb_pkg::PAL_AW-1:0]  cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic                        last_q, last_d;
  logic                        blend_q, blend_d;
  logic [psb_pkg::PAL_AW-1:0]  out_idx_q;
  logic [psb_pkg::ROW_W-1:0]   row_q;
  psb_pkg::rgb_t               base_q, partner_q;
  psb_pkg::target_t            target_q, target_d;

  logic                        in_acc;
  logic                        q_valid_row;
  logic                        q_blend;
  logic [psb_pkg::PAL_AW-1:0]  partner_in;
  logic                        q_shortcut;
  logic                        out_free;

  logic                        ram_we;
  logic [psb_pkg::PAL_AW-1:0]  ram_raddr;
  psb_pkg::rgb_t               ram_wdata;
  logic [psb_pkg::RGB_W-1:0]   ram_rdata;
  psb_pkg::rgb_t               entry;

  psb_pkg::dist_ctrl_t         dctrl;
  logic [psb_pkg::PAL_AW-1:0]  best_idx;

  logic [5:0]                  scale;
  logic [13:0]                 sh_r, sh_g, sh_b;
  logic [9:0]                  bl_r, bl_g, bl_b;
  logic [19:0]                 dv_r, dv_g, dv_b;

  // Decode the incoming item
  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign in_acc        = in_ch_i.valid && in_ch_i.ready;
  assign q_valid_row   = (in_ch_i.row <= psb_pkg::LAST_ROW);
  assign q_blend       = (in_ch_i.row >= psb_pkg::SHADE_ROWS);
  assign partner_in    = in_ch_i.row[7:0] - psb_pkg::SHADE_ROWS[7:0];
  assign q_shortcut    = (in_ch_i.column == psb_pkg::LAST_INDEX) ||
                         (q_blend && (partner_in == psb_pkg::LAST_INDEX));
  assign out_free      = !out_valid_q || out_ch_o.ready;

  // Palette RAM
  assign ram_we    = in_acc && (in_ch_i.action == psb_pkg::ACT_WRITE);
  assign ram_wdata = '{r: in_ch_i.red_in, g: in_ch_i.green_in, b: in_ch_i.blue_in};
  assign entry     = psb_pkg::rgb_t'(ram_rdata);

  always_comb begin
    unique case (state_q)
      ST_IDLE:    ram_raddr = in_ch_i.column;
      ST_RD_BASE: ram_raddr = row_q[7:0] - psb_pkg::SHADE_ROWS[7:0];
      ST_SCAN:    ram_raddr = cnt_q + 8'd1;
      default:    ram_raddr = '0;
    endcase
  end

  psb_ram #(
    .WIDTH(psb_pkg::RGB_W),
    .DEPTH(psb_pkg::PAL_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_ch_i.entry_index),
    .wdata_i (ram_wdata),
    .re_i    (1'b1),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Target colour: shade by base * (63 - row) >> 5, or blend (2 * base + partner) / 3
  always_comb begin
    scale = psb_pkg::SHADE_MAX - row_q[5:0];
    sh_r  = {6'd0, base_q.r} * {8'd0, scale};
    sh_g  = {6'd0, base_q.g} * {8'd0, scale};
    sh_b  = {6'd0, base_q.b} * {8'd0, scale};
    bl_r  = {1'b0, base_q.r, 1'b0} + {2'b00, partner_q.r};
    bl_g  = {1'b0, base_q.g, 1'b0} + {2'b00, partner_q.g};
    bl_b  = {1'b0, base_q.b, 1'b0} + {2'b00, partner_q.b};
    dv_r  = {10'd0, bl_r} * {10'd0, psb_pkg::RECIP3};
    dv_g  = {10'd0, bl_g} * {10'd0, psb_pkg::RECIP3};
    dv_b  = {10'd0, bl_b} * {10'd0, psb_pkg::RECIP3};
    if (blend_q) begin
      target_d.r = dv_r[psb_pkg::RECIP3_SHIFT +: psb_pkg::TGT_W];
      target_d.g = dv_g[psb_pkg::RECIP3_SHIFT +: psb_pkg::TGT_W];
      target_d.b = dv_b[psb_pkg::RECIP3_SHIFT +: psb_pkg::TGT_W];
    end else begin
      target_d.r = sh_r[psb_pkg::SHADE_SHIFT +: psb_pkg::TGT_W];
      target_d.g = sh_g[psb_pkg::SHADE_SHIFT +: psb_pkg::TGT_W];
      target_d.b = sh_b[psb_pkg::SHADE_SHIFT +: psb_pkg::TGT_W];
    end
  end

  // Shared distance unit
  assign dctrl.clear = (state_q == ST_TARGET);
  assign dctrl.step  = (state_q == ST_SCAN);

  psb_dist_unit u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (dctrl),
    .target_i   (target_q),
    .entry_i    (entry),
    .index_i    (cnt_q),
    .best_idx_o (best_idx)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    blend_d     = blend_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_ch_i.action == psb_pkg::ACT_QUERY) && q_valid_row) begin
          blend_d = q_blend;
          last_d  = q_shortcut;
          state_d = q_shortcut ? ST_FINISH : ST_RD_BASE;
        end
      end
      ST_RD_BASE: state_d = blend_q ? ST_RD_PART : ST_TARGET;
      ST_RD_PART: state_d = ST_TARGET;
      ST_TARGET: begin
        cnt_d   = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 8'd1;
        if (cnt_q == (psb_pkg::LAST_INDEX - 8'd1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      blend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      blend_q     <= blend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold operands, target and result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_q <= in_ch_i.row;
    end
    if (state_q == ST_RD_BASE) begin
      base_q <= entry;
    end
    if (state_q == ST_RD_PART) begin
      partner_q <= entry;
    end
    if (state_q == ST_TARGET) begin
      target_q <= target_d;
    end
    if ((state_q == ST_FINISH) && out_free) begin
      out_idx_q <= last_q ? psb_pkg::LAST_INDEX : best_idx;
    end
  end

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.color_index = out_idx_q;

  // Scan never runs past entry 254
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q < psb_pkg::LAST_INDEX))
    else $error("scan counter past last entry");

  // A palette write leaves the block idle
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_ch_i.action == psb_pkg::ACT_WRITE)) |=> (state_q == ST_IDLE))
    else $error("palette write left the idle state");

  // A query on the last column goes straight to the result stage
  a_last_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_ch_i.action == psb_pkg::ACT_QUERY) && q_valid_row &&
     (in_ch_i.column == psb_pkg::LAST_INDEX)) |=> ((state_q == ST_FINISH) && last_q))
    else $error("last column query did not short-cut");

endmodule
